/* hdl/grid_component_grouper_defines.svh */
// ----------------------------------------------------------------------------
// grid_component_grouper assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef GRID_COMPONENT_GROUPER_DEFINES_SVH
`define GRID_COMPONENT_GROUPER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GCG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assert failed");
`define GCG_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("never failed");
`else
`define GCG_ASSERT(label, clk, rst, prop)
`define GCG_NEVER(label, clk, rst, cond)
`endif
`endif

/* hdl/gcg_pkg.sv */
// ----------------------------------------------------------------------------
// gcg_pkg
// Shared constants, types and helpers of the grid component grouper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gcg_pkg;
   localparam int GRID_ROWS = 16;
   localparam int GRID_COLS = 16;
   localparam int CELLS     = GRID_ROWS * GRID_COLS;
   localparam int ROW_W     = $clog2(GRID_ROWS);
   localparam int COL_W     = $clog2(GRID_COLS);
   localparam int CELL_W    = $clog2(CELLS);
   localparam int DEPTH_W   = $clog2(CELLS + 1);
   localparam int CMP_W     = 8;
   localparam int FIELD_W   = 4;
   localparam int CFG_W     = 5;
   localparam int GRP_W     = 8;
   localparam int GRP_OUT_W = 7;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef enum logic {CMD_LOAD = 1'b0, CMD_FETCH = 1'b1} cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             in_grid;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             occupied;
   } cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [1:0]       dir;
   } frame_type;

   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   function automatic logic [CELL_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
      return CELL_W'(CELL_W'(r) * CELL_W'(GRID_COLS) + CELL_W'(c));
   endfunction
endpackage

/* hdl/gcg_if.sv */
// ----------------------------------------------------------------------------
// gcg channel interfaces
// Request and response channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface gcg_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [3:0] cell_row;
   logic [3:0] cell_col;
   logic       occupied;
   modport source (output valid, command, cell_row, cell_col, occupied, input ready);
   modport sink   (input valid, command, cell_row, cell_col, occupied, output ready);
endinterface

interface gcg_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] group_index;
   logic [3:0] square_row;
   logic [3:0] square_col;
   logic       last_in_group;
   logic       none_left;
   modport source (output valid, group_index, square_row, square_col, last_in_group,
                   none_left, input ready);
   modport sink   (input valid, group_index, square_row, square_col, last_in_group,
                   none_left, output ready);
endinterface

/* hdl/gcg_front.sv */
// ----------------------------------------------------------------------------
// gcg_front
// Accepts requests, decodes them and queues them for the walk engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gcg_front (
   input  logic              clock,
   input  logic              reset,
   gcg_req_if.sink           req_ch,
   output logic              q_valid,
   input  logic              q_ready,
   output gcg_pkg::cmd_type  q_item
);
   gcg_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   gcg_pkg::cmd_type dec;
   logic             push;
   logic             pop;

   always_comb begin
      dec.kind     = req_ch.command ? gcg_pkg::CMD_FETCH : gcg_pkg::CMD_LOAD;
      dec.in_grid  = (gcg_pkg::CMP_W'(req_ch.cell_row) < gcg_pkg::CMP_W'(gcg_pkg::GRID_ROWS)) &&
                     (gcg_pkg::CMP_W'(req_ch.cell_col) < gcg_pkg::CMP_W'(gcg_pkg::GRID_COLS));
      dec.row      = gcg_pkg::ROW_W'(req_ch.cell_row);
      dec.col      = gcg_pkg::COL_W'(req_ch.cell_col);
      dec.occupied = req_ch.occupied;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push    = req_ch.valid && req_ch.ready;
   assign q_valid = (count_ff != 2'd0);
   assign pop     = q_valid && q_ready;
   assign q_item  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            q_ff[wr_ptr_ff] <= dec;
            wr_ptr_ff       <= ~wr_ptr_ff;
         end
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= 2'(count_ff + 2'(push) - 2'(pop));
      end
   end
endmodule

/* hdl/gcg_back.sv */
// ----------------------------------------------------------------------------
// gcg_back
// Walk engine: grid and visited map memories, frame stack, scan, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_component_grouper_defines.svh"
module gcg_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  gcg_pkg::cmd_type           q_item,
   input  logic [gcg_pkg::CFG_W-1:0]  rows_cfg,
   input  logic [gcg_pkg::CFG_W-1:0]  cols_cfg,
   gcg_rsp_if.source                  rsp_ch
);
   localparam int ROW_W  = gcg_pkg::ROW_W;
   localparam int COL_W  = gcg_pkg::COL_W;
   localparam int CELL_W = gcg_pkg::CELL_W;
   localparam int CMP_W  = gcg_pkg::CMP_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_ADV, S_CHK, S_POP, S_SCAN, S_SCHK, S_EMIT
   } state_type;

   state_type                     state_ff;
   logic                          phase_ff;
   logic [gcg_pkg::DEPTH_W-1:0]   depth_ff;
   gcg_pkg::frame_type            top_ff;
   logic [ROW_W-1:0]              cur_r_ff;
   logic [COL_W-1:0]              cur_c_ff;
   logic                          ahead_valid_ff;
   logic [ROW_W-1:0]              ahead_r_ff;
   logic [COL_W-1:0]              ahead_c_ff;
   logic [gcg_pkg::GRP_W-1:0]     grp_ff;
   logic [ROW_W-1:0]              scan_r_ff;
   logic [COL_W-1:0]              scan_c_ff;
   logic                          scan_done_ff;
   logic                          last_ff;
   logic                          none_ff;
   logic [CELL_W-1:0]             clr_idx_ff;
   logic                          clr_cells_ff;
   logic                          vis_dirty_ff;
   logic                          cell_mem [gcg_pkg::CELLS];
   logic                          vis_mem [gcg_pkg::CELLS];
   logic                          cell_rd_ff;
   logic                          vis_rd_ff;
   gcg_pkg::frame_type            stack_mem [gcg_pkg::CELLS];
   gcg_pkg::frame_type            rd_data_ff;

   logic                          rsp_valid_ff;
   logic [gcg_pkg::GRP_OUT_W-1:0] rsp_grp_ff;
   logic [3:0]                    rsp_row_ff;
   logic [3:0]                    rsp_col_ff;
   logic                          rsp_last_ff;
   logic                          rsp_none_ff;

   logic [CMP_W-1:0]  rows_eff;
   logic [CMP_W-1:0]  cols_eff;
   logic [ROW_W:0]    nr;
   logic [COL_W:0]    nc;
   logic              nb_in;
   logic [CELL_W-1:0] nb_idx;
   logic              nb_found;
   logic              is_pop;
   logic [CELL_W-1:0] scan_idx;
   logic              scan_in;
   logic              scan_hit;
   logic [CELL_W-1:0] rd_addr;
   logic              load_go;
   logic              cell_we;
   logic [CELL_W-1:0] cell_wa;
   logic              cell_wd;
   logic              vis_we;
   logic [CELL_W-1:0] vis_wa;
   logic              vis_wd;
   logic              out_free;

   always_comb begin
      rows_eff = (CMP_W'(rows_cfg) > CMP_W'(gcg_pkg::GRID_ROWS)) ?
                 CMP_W'(gcg_pkg::GRID_ROWS) : CMP_W'(rows_cfg);
      cols_eff = (CMP_W'(cols_cfg) > CMP_W'(gcg_pkg::GRID_COLS)) ?
                 CMP_W'(gcg_pkg::GRID_COLS) : CMP_W'(cols_cfg);
      nr = (ROW_W+1)'(top_ff.row);
      nc = (COL_W+1)'(top_ff.col);
      unique case (top_ff.dir)
         gcg_pkg::DIR_RIGHT: nc = (COL_W+1)'(nc + 1'b1);
         gcg_pkg::DIR_LEFT:  nc = (COL_W+1)'(nc - 1'b1);
         gcg_pkg::DIR_DOWN:  nr = (ROW_W+1)'(nr + 1'b1);
         default:            nr = (ROW_W+1)'(nr - 1'b1);
      endcase
      nb_in    = (CMP_W'(nr) < rows_eff) && (CMP_W'(nc) < cols_eff);
      nb_idx   = gcg_pkg::cell_idx(nr[ROW_W-1:0], nc[COL_W-1:0]);
      nb_found = nb_in && cell_rd_ff && !vis_rd_ff;
      is_pop   = (top_ff.dir == gcg_pkg::DIR_UP);
      scan_idx = gcg_pkg::cell_idx(scan_r_ff, scan_c_ff);
      scan_in  = (CMP_W'(scan_r_ff) < rows_eff) && (CMP_W'(scan_c_ff) < cols_eff);
      scan_hit = scan_in && cell_rd_ff && !vis_rd_ff;
      rd_addr  = (state_ff == S_SCAN) ? scan_idx : nb_idx;

      load_go  = (state_ff == S_IDLE) && q_valid && (q_item.kind == gcg_pkg::CMD_LOAD);
      cell_we  = (state_ff == S_CLEAR && clr_cells_ff) || (load_go && q_item.in_grid);
      cell_wa  = (state_ff == S_CLEAR) ? clr_idx_ff : gcg_pkg::cell_idx(q_item.row, q_item.col);
      cell_wd  = (state_ff == S_CLEAR) ? 1'b0 : q_item.occupied;
      vis_we   = (state_ff == S_CLEAR) || (state_ff == S_CHK && nb_found) ||
                 (state_ff == S_SCHK && scan_hit);
      vis_wa   = (state_ff == S_CLEAR) ? clr_idx_ff :
                 (state_ff == S_SCHK) ? scan_idx : nb_idx;
      vis_wd   = (state_ff != S_CLEAR);
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign q_ready  = (state_ff == S_IDLE);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.group_index   = rsp_grp_ff;
   assign rsp_ch.square_row    = rsp_row_ff;
   assign rsp_ch.square_col    = rsp_col_ff;
   assign rsp_ch.last_in_group = rsp_last_ff;
   assign rsp_ch.none_left     = rsp_none_ff;

   // grid and visited maps, registered read
   always_ff @(posedge clock) begin
      cell_rd_ff <= cell_mem[rd_addr];
      vis_rd_ff  <= vis_mem[rd_addr];
      if (cell_we) cell_mem[cell_wa] <= cell_wd;
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
   end

   // frame stack: top frame lives in top_ff, frames below it in the memory
   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem[CELL_W'(depth_ff - 2'd2)];
      if (state_ff == S_CHK && nb_found && !is_pop)
         stack_mem[CELL_W'(depth_ff - 1'b1)] <=
            '{row: top_ff.row, col: top_ff.col, dir: 2'(top_ff.dir + 1'b1)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         phase_ff       <= 1'b0;
         depth_ff       <= '0;
         ahead_valid_ff <= 1'b0;
         grp_ff         <= '0;
         scan_r_ff      <= '0;
         scan_c_ff      <= '0;
         scan_done_ff   <= 1'b0;
         clr_idx_ff     <= '0;
         clr_cells_ff   <= 1'b1;
         vis_dirty_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= CELL_W'(clr_idx_ff + 1'b1);
               if (clr_idx_ff == CELL_W'(gcg_pkg::CELLS - 1)) begin
                  clr_cells_ff <= 1'b0;
                  vis_dirty_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  if (q_item.kind == gcg_pkg::CMD_LOAD) begin
                     depth_ff       <= '0;
                     scan_r_ff      <= '0;
                     scan_c_ff      <= '0;
                     scan_done_ff   <= 1'b0;
                     grp_ff         <= '0;
                     ahead_valid_ff <= 1'b0;
                     if (vis_dirty_ff) state_ff <= S_CLEAR;
                  end else begin
                     state_ff <= S_ADV;
                     if (ahead_valid_ff) begin
                        cur_r_ff       <= ahead_r_ff;
                        cur_c_ff       <= ahead_c_ff;
                        ahead_valid_ff <= 1'b0;
                        phase_ff       <= 1'b1;
                     end else begin
                        phase_ff <= 1'b0;
                     end
                  end
               end
            end
            S_ADV: begin
               if (depth_ff == '0) begin
                  if (!phase_ff) begin
                     state_ff <= S_SCAN;
                  end else begin
                     last_ff  <= 1'b1;
                     none_ff  <= 1'b0;
                     state_ff <= S_EMIT;
                  end
               end else begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (nb_found) begin
                  vis_dirty_ff <= 1'b1;
                  if (!is_pop) depth_ff <= gcg_pkg::DEPTH_W'(depth_ff + 1'b1);
                  top_ff <= '{row: nr[ROW_W-1:0], col: nc[COL_W-1:0], dir: gcg_pkg::DIR_RIGHT};
                  if (!phase_ff) begin
                     cur_r_ff <= nr[ROW_W-1:0];
                     cur_c_ff <= nc[COL_W-1:0];
                     phase_ff <= 1'b1;
                     state_ff <= S_ADV;
                  end else begin
                     ahead_r_ff     <= nr[ROW_W-1:0];
                     ahead_c_ff     <= nc[COL_W-1:0];
                     ahead_valid_ff <= 1'b1;
                     last_ff        <= 1'b0;
                     none_ff        <= 1'b0;
                     state_ff       <= S_EMIT;
                  end
               end else if (is_pop) begin
                  depth_ff <= gcg_pkg::DEPTH_W'(depth_ff - 1'b1);
                  if (depth_ff > gcg_pkg::DEPTH_W'(1)) state_ff <= S_POP;
                  else state_ff <= S_ADV;
               end else begin
                  top_ff.dir <= 2'(top_ff.dir + 1'b1);
                  state_ff   <= S_ADV;
               end
            end
            S_POP: begin
               top_ff   <= rd_data_ff;
               state_ff <= S_ADV;
            end
            S_SCAN: begin
               if (scan_done_ff) begin
                  none_ff  <= 1'b1;
                  last_ff  <= 1'b0;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_SCHK;
               end
            end
            S_SCHK: begin
               if (scan_c_ff == COL_W'(gcg_pkg::GRID_COLS - 1)) begin
                  scan_c_ff <= '0;
                  if (scan_r_ff == ROW_W'(gcg_pkg::GRID_ROWS - 1)) scan_done_ff <= 1'b1;
                  else scan_r_ff <= ROW_W'(scan_r_ff + 1'b1);
               end else begin
                  scan_c_ff <= COL_W'(scan_c_ff + 1'b1);
               end
               if (scan_hit) begin
                  grp_ff       <= gcg_pkg::GRP_W'(grp_ff + 1'b1);
                  vis_dirty_ff <= 1'b1;
                  top_ff   <= '{row: scan_r_ff, col: scan_c_ff, dir: gcg_pkg::DIR_RIGHT};
                  depth_ff <= gcg_pkg::DEPTH_W'(1);
                  cur_r_ff <= scan_r_ff;
                  cur_c_ff <= scan_c_ff;
                  phase_ff <= 1'b1;
                  state_ff <= S_ADV;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_none_ff  <= none_ff;
                  rsp_last_ff  <= last_ff;
                  if (none_ff) begin
                     rsp_grp_ff <= '0;
                     rsp_row_ff <= '0;
                     rsp_col_ff <= '0;
                  end else begin
                     rsp_grp_ff <= gcg_pkg::GRP_OUT_W'(grp_ff - 1'b1);
                     rsp_row_ff <= 4'(cur_r_ff);
                     rsp_col_ff <= 4'(cur_c_ff);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `GCG_ASSERT(a_depth_max, clock, reset, depth_ff <= gcg_pkg::DEPTH_W'(gcg_pkg::CELLS))
   `GCG_NEVER(a_pop_empty, clock, reset, state_ff == S_POP && depth_ff == '0)
   `GCG_ASSERT(a_ahead_stack, clock, reset, ahead_valid_ff |-> depth_ff != '0)
   `GCG_ASSERT(a_none_zero, clock, reset, (rsp_valid_ff && rsp_none_ff) |-> (rsp_grp_ff == '0 && rsp_row_ff == '0 && rsp_col_ff == '0 && !rsp_last_ff))
endmodule

/* hdl/grid_component_grouper.sv */
// ----------------------------------------------------------------------------
// grid_component_grouper
// Groups occupied grid cells into 4-connected components, one cell per fetch.
// ----------------------------------------------------------------------------
// After reset the engine clears its grid and visited maps before it takes the
// first transfer. A load restarts the walk; if the walk has marked any cell
// since the last restart, a clearing pass of the visited map follows. A fetch
// is taken, then probes each neighbor (address, then registered map read),
// pops frames (registered stack read), notes when the stack runs empty, scans
// grid positions for a new group (address, then registered map read, with a
// final step once the scan is past the last position), and loads the output
// register, which waits while a response is still unaccepted. A two-entry
// request queue and the output register decouple the channels from the engine.
`timescale 1ns / 1ps
module grid_component_grouper (
   input  logic                      clock,
   input  logic                      reset,
   gcg_req_if.sink                   req_ch,
   gcg_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [gcg_pkg::CFG_W-1:0] csr_wr_data
);
   logic [gcg_pkg::CFG_W-1:0] rows_ff;
   logic [gcg_pkg::CFG_W-1:0] cols_ff;
   logic                      q_valid;
   logic                      q_ready;
   gcg_pkg::cmd_type          q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= gcg_pkg::CFG_W'(10);
         cols_ff <= gcg_pkg::CFG_W'(10);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gcg_pkg::CSR_ROWS: rows_ff <= csr_wr_data;
            gcg_pkg::CSR_COLS: cols_ff <= csr_wr_data;
         endcase
      end
   end

   gcg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   gcg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item),
      .rows_cfg (rows_ff),
      .cols_cfg (cols_ff),
      .rsp_ch   (rsp_ch)
   );
endmodule
